@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the mode sequencer.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/msum_pkg.sv @@
// Package for the mode sequencer: mode, kind, event and command codes,
// the mode-to-mask table and the scan widths. No dependencies.
package msum_pkg;

    localparam int NUM_UNITS  = 8;
    localparam int MASK_W     = 8;
    localparam int SCAN_W     = (NUM_UNITS < MASK_W) ? NUM_UNITS : MASK_W;
    localparam int UNIT_IDX_W = 3;
    localparam int MODE_W     = 4;
    localparam int CMD_W      = 10;

    // Modes.
    localparam logic [MODE_W-1:0] MODE_INIT    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CW      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_WODEX   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_AMEAS   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ACTRL   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SCIENCE = 4'd5;
    localparam logic [MODE_W-1:0] MODE_TELEM   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FM      = 4'd7;
    localparam logic [MODE_W-1:0] MODE_POWER   = 4'd14;
    localparam logic [MODE_W-1:0] MODE_STDBY   = 4'd15;

    // Item kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_CMD   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Event codes.
    localparam logic [2:0] EV_DEPLOY_OK   = 3'd0;
    localparam logic [2:0] EV_DEPLOY_FAIL = 3'd1;
    localparam logic [2:0] EV_BATT_HIGH   = 3'd2;
    localparam logic [2:0] EV_BATT_LOW    = 3'd3;
    localparam logic [2:0] EV_STORE_EMPTY = 3'd4;

    // Ground command numbers.
    localparam logic [CMD_W-1:0] CMD_CW        = 10'd1;
    localparam logic [CMD_W-1:0] CMD_WODEX_A   = 10'd2;
    localparam logic [CMD_W-1:0] CMD_WODEX_B   = 10'd3;
    localparam logic [CMD_W-1:0] CMD_AMEAS     = 10'd4;
    localparam logic [CMD_W-1:0] CMD_ACTRL     = 10'd5;
    localparam logic [CMD_W-1:0] CMD_SCIENCE   = 10'd6;
    localparam logic [CMD_W-1:0] CMD_FM        = 10'd7;
    localparam logic [CMD_W-1:0] CMD_STDBY     = 10'd8;
    localparam logic [CMD_W-1:0] CMD_TELEM_A   = 10'd9;
    localparam logic [CMD_W-1:0] CMD_TELEM_B   = 10'd10;
    localparam logic [CMD_W-1:0] CMD_LEAVE_TEL = 10'd12;
    localparam logic [CMD_W-1:0] CMD_ERASE     = 10'd1001;

    // Enabled units for each mode.
    localparam logic [MASK_W-1:0] MODE_MASKS [0:15] = '{
        8'h01, 8'h0A, 8'h02, 8'h42, 8'h42, 8'h46, 8'h12, 8'h22,
        8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h00
    };

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage

@@ src/mode_sequencer_with_unit_masks.sv @@
// Mode sequencer top level: decodes items into mode switches and streams unit changes.
// Depends on msum_pkg and assert_macros.svh.
// An accepted item loads the scan registers and enters the scan state; the scan then steps
// upward from unit 0 (up to SCAN_W), registering one result per changed unit, and an item
// without changes gives a single empty result. A new item waits until the scan is done.
// Reset (rst_n low, asynchronous) gives init mode, every unit suspended, no result pending.
`include "assert_macros.svh"

module mode_sequencer_with_unit_masks
    import msum_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic [2:0]            event_code,
    input  logic [CMD_W-1:0]      command_number,
    input  logic [MODE_W-1:0]     saved_mode,
    input  logic                  antenna_deployed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  unit_valid,
    output logic [UNIT_IDX_W-1:0] unit_index,
    output logic                  resume,
    output logic [MODE_W-1:0]     new_mode,
    output logic                  erase_store,
    output logic                  last
);

    // Architectural state: the current mode and the mask of enabled units.
    logic [MODE_W-1:0]     mode_reg;
    logic [MASK_W-1:0]     mask_reg;
    state_t                state_reg;

    // Per-item scan state. The change mask and the old mask are shifted right one bit per
    // cycle while the output register can take a beat, and the unit counter tracks which unit sits at bit zero.
    logic [SCAN_W-1:0]     delta_sh_reg;
    logic [SCAN_W-1:0]     old_sh_reg;
    logic [UNIT_IDX_W-1:0] unit_cnt_reg;
    logic [MODE_W-1:0]     item_mode_reg;
    logic                  item_erase_reg;

    // Output register. It holds one result beat, so the next input beat can be
    // taken while the last result of the previous item still waits.
    logic                  out_valid_reg;
    logic                  out_unit_valid_reg;
    logic [UNIT_IDX_W-1:0] out_index_reg;
    logic                  out_resume_reg;
    logic [MODE_W-1:0]     out_mode_reg;
    logic                  out_erase_reg;
    logic                  out_last_reg;

    logic                  in_fire;
    logic                  out_free;
    logic                  sw;
    logic                  erase;
    logic [MODE_W-1:0]     target;
    logic [MASK_W-1:0]     target_mask;
    logic [MASK_W-1:0]     delta_full;
    logic                  scan_step;
    logic                  scan_empty;
    logic                  scan_hit;
    logic                  scan_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Decode the item into a target mode, a switch flag and an erase flag. Commands other than
    // "leave telemetry" switch only when the target differs from the current mode.
    always_comb
    begin
        sw     = 1'b0;
        erase  = 1'b0;
        target = mode_reg;
        unique case (kind)
            KIND_START:
            begin
                sw = 1'b1;
                if (saved_mode == MODE_STDBY)
                    target = saved_mode;
                else if (antenna_deployed)
                    target = MODE_WODEX;
                else
                    target = MODE_INIT;
            end
            KIND_EVENT:
            begin
                unique case (event_code) inside
                    EV_DEPLOY_OK, EV_DEPLOY_FAIL:
                    begin
                        target = MODE_WODEX;
                        sw     = (mode_reg == MODE_INIT);
                    end
                    EV_BATT_HIGH:
                    begin
                        target = MODE_WODEX;
                        sw     = (mode_reg == MODE_POWER);
                    end
                    EV_BATT_LOW:
                    begin
                        target = MODE_POWER;
                        sw     = (mode_reg != MODE_POWER);
                    end
                    EV_STORE_EMPTY:
                    begin
                        target = MODE_WODEX;
                        sw     = (mode_reg == MODE_TELEM);
                    end
                    default:
                    begin
                        sw = 1'b0;
                    end
                endcase
                // An event that causes no switch reports the mode it found.
                if (!sw)
                    target = mode_reg;
            end
            KIND_CMD:
            begin
                unique case (command_number) inside
                    CMD_CW:                   target = MODE_CW;
                    CMD_WODEX_A, CMD_WODEX_B: target = MODE_WODEX;
                    CMD_AMEAS:                target = MODE_AMEAS;
                    CMD_ACTRL:                target = MODE_ACTRL;
                    CMD_SCIENCE:              target = MODE_SCIENCE;
                    CMD_FM:                   target = MODE_FM;
                    CMD_STDBY:                target = MODE_STDBY;
                    CMD_TELEM_A, CMD_TELEM_B: target = MODE_TELEM;
                    CMD_LEAVE_TEL:            target = MODE_WODEX;
                    default:                  target = mode_reg;
                endcase
                unique case (command_number) inside
                    CMD_CW, CMD_WODEX_A, CMD_WODEX_B, CMD_AMEAS, CMD_ACTRL,
                    CMD_SCIENCE, CMD_FM, CMD_STDBY, CMD_TELEM_A, CMD_TELEM_B:
                    begin
                        sw = (mode_reg != target);
                    end
                    CMD_LEAVE_TEL:
                    begin
                        sw = (mode_reg == MODE_TELEM);
                    end
                    CMD_ERASE:
                    begin
                        erase = (mode_reg == MODE_STDBY);
                    end
                    default:
                    begin
                        sw = 1'b0;
                    end
                endcase
                if (!sw)
                    target = mode_reg;
            end
            KIND_OTHER:
            begin
                sw = 1'b0;
            end
            default:
            begin
                sw = 1'b0;
            end
        endcase
    end

    assign target_mask = MODE_MASKS[target];
    assign delta_full  = sw ? (mask_reg ^ target_mask) : '0;

    // One scan step per cycle while the output register can take a beat. An
    // all-zero change mask gives the single empty result; otherwise a set bit
    // at position zero gives one unit change.
    assign scan_step  = (state_reg == ST_SCAN) && out_free;
    assign scan_empty = (delta_sh_reg == '0);
    assign scan_hit   = !scan_empty && delta_sh_reg[0];
    assign scan_last  = scan_empty || ((delta_sh_reg >> 1) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_INIT;
            mask_reg      <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire && sw)
            begin
                mode_reg <= target;
                mask_reg <= target_mask;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (scan_step && (scan_empty || (scan_hit && scan_last)))
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (scan_step && (scan_empty || scan_hit))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            delta_sh_reg   <= delta_full[SCAN_W-1:0];
            old_sh_reg     <= mask_reg[SCAN_W-1:0];
            unit_cnt_reg   <= '0;
            item_mode_reg  <= target;
            item_erase_reg <= erase;
        end
        else if (scan_step && !scan_empty)
        begin
            delta_sh_reg <= delta_sh_reg >> 1;
            old_sh_reg   <= old_sh_reg >> 1;
            unit_cnt_reg <= unit_cnt_reg + 1'b1;
        end

        if (scan_step && (scan_empty || scan_hit))
        begin
            out_unit_valid_reg <= scan_hit;
            out_index_reg      <= scan_hit ? unit_cnt_reg : '0;
            out_resume_reg     <= scan_hit && !old_sh_reg[0];
            out_mode_reg       <= item_mode_reg;
            out_erase_reg      <= item_erase_reg;
            out_last_reg       <= scan_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign unit_valid  = out_unit_valid_reg;
    assign unit_index  = out_index_reg;
    assign resume      = out_resume_reg;
    assign new_mode    = out_mode_reg;
    assign erase_store = out_erase_reg;
    assign last        = out_last_reg;

    // A result that is not the final one means the scan is still running.
    `ASSERT_IMP(a_nonlast_scanning, out_valid_reg && !out_last_reg, state_reg == ST_SCAN)
    // An accepted input beat always starts a scan.
    `ASSERT_NXT(a_accept_scans, in_fire, state_reg == ST_SCAN)
    // An erase request only ever rides on an empty result.
    `ASSERT_IMP(a_erase_empty, out_valid_reg && out_erase_reg, !out_unit_valid_reg)

endmodule
